// ===== rtl/core/peq_pkg.sv =====
// ----------------------------------------------------------------------------
// peq_pkg
// Shared types, widths and command codes for the peaking EQ biquad unit.
// ----------------------------------------------------------------------------
package peq_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 18;
  localparam int DELAY_W        = 40;
  localparam int PROD_W         = COEF_W + SAMPLE_W;
  localparam int ACC_W          = DELAY_W + 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = COEF_W;
  localparam int COEF_FRAC_BITS = 14;

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [DELAY_W-1:0]    delay_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_ENABLE = 3'd0;
  localparam cfg_idx_t REG_B0     = 3'd1;
  localparam cfg_idx_t REG_B1     = 3'd2;
  localparam cfg_idx_t REG_B2     = 3'd3;
  localparam cfg_idx_t REG_A1     = 3'd4;
  localparam cfg_idx_t REG_A2     = 3'd5;

  localparam coef_t B0_RESET = 18'sd16384;

  // coefficient select
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  // accumulator base select
  localparam logic [1:0] BASE_ACC  = 2'd0;
  localparam logic [1:0] BASE_D1   = 2'd1;
  localparam logic [1:0] BASE_D2   = 2'd2;
  localparam logic [1:0] BASE_ZERO = 2'd3;

  typedef struct packed {
    logic       load_x;
    logic       mac_en;
    logic [2:0] coef_sel;
    logic [1:0] base_sel;
    logic       sub;
    logic       use_y;
    logic       y_load;
    logic       y_pass;
    logic       d1_load;
    logic       d2_load;
    logic       out_load;
  } peq_cmd_t;

  typedef struct packed {
    logic enable;
    logic out_busy;
  } peq_status_t;

endpackage

// ===== rtl/core/peq_in_if.sv =====
// ----------------------------------------------------------------------------
// peq_in_if
// Input sample channel: left and right sample with valid/ready.
// ----------------------------------------------------------------------------
interface peq_in_if import peq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/core/peq_out_if.sv =====
// ----------------------------------------------------------------------------
// peq_out_if
// Result channel: one mono sample per item with valid/ready.
// ----------------------------------------------------------------------------
interface peq_out_if import peq_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

// ===== rtl/core/peq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// peq_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface peq_cfg_if import peq_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/peq_datapath.sv =====
// ----------------------------------------------------------------------------
// peq_datapath
// Config registers, shared multiply-accumulate, delay state and output register.
// ----------------------------------------------------------------------------
module peq_datapath import peq_pkg::*; #(
  parameter int FRAC_BITS = COEF_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  peq_cmd_t      cmd,
  output peq_status_t   status,
  input  sample_t       left_sample,
  input  sample_t       right_sample,
  peq_cfg_if.sink       cfg,
  peq_out_if.source     out_ch
);

  localparam acc_t D_MAX = {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
  localparam acc_t D_MIN = {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
  localparam acc_t Y_MAX = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam acc_t Y_MIN = {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic    enable_r, enable_nxt;
  coef_t   b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt, a1_r, a1_nxt, a2_r, a2_nxt;
  sample_t x_r, x_nxt, y_r, y_nxt, out_sample_r, out_sample_nxt;
  logic    out_valid_r, out_valid_nxt;
  delay_t  d1_r, d1_nxt, d2_r, d2_nxt;
  acc_t    acc_r, acc_nxt;

  logic signed [SAMPLE_W:0] mono_sum;
  coef_t   coef_mux;
  sample_t op_mux;
  prod_t   prod;
  acc_t    prod_ext, base, quot, quot_tz, acc_sat;
  logic    frac_nz;
  sample_t y_sat;
  delay_t  d_sat;

  assign cfg.ready    = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;
  assign status.enable   = enable_r;
  assign status.out_busy = out_valid_r & ~out_ch.ready;

  assign mono_sum = {left_sample[SAMPLE_W-1], left_sample}
                  + {right_sample[SAMPLE_W-1], right_sample};

  always_comb begin
    case (cmd.coef_sel)
      SEL_B0:  coef_mux = b0_r;
      SEL_B1:  coef_mux = b1_r;
      SEL_B2:  coef_mux = b2_r;
      SEL_A1:  coef_mux = a1_r;
      SEL_A2:  coef_mux = a2_r;
      default: coef_mux = '0;
    endcase
    op_mux   = cmd.use_y ? y_r : x_r;
    prod     = coef_mux * op_mux;
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    case (cmd.base_sel)
      BASE_ACC: base = acc_r;
      BASE_D1:  base = {{(ACC_W-DELAY_W){d1_r[DELAY_W-1]}}, d1_r};
      BASE_D2:  base = {{(ACC_W-DELAY_W){d2_r[DELAY_W-1]}}, d2_r};
      default:  base = '0;
    endcase
  end

  // truncate toward zero, then saturate
  always_comb begin
    quot    = acc_r >>> FRAC_BITS;
    frac_nz = |acc_r[FRAC_BITS-1:0];
    quot_tz = quot + {{(ACC_W-1){1'b0}}, acc_r[ACC_W-1] & frac_nz};
    if (quot_tz > Y_MAX)      y_sat = Y_MAX[SAMPLE_W-1:0];
    else if (quot_tz < Y_MIN) y_sat = Y_MIN[SAMPLE_W-1:0];
    else                      y_sat = quot_tz[SAMPLE_W-1:0];
    if (acc_r > D_MAX)        acc_sat = D_MAX;
    else if (acc_r < D_MIN)   acc_sat = D_MIN;
    else                      acc_sat = acc_r;
    d_sat = acc_sat[DELAY_W-1:0];
  end

  always_comb begin
    enable_nxt = enable_r;
    b0_nxt = b0_r;
    b1_nxt = b1_r;
    b2_nxt = b2_r;
    a1_nxt = a1_r;
    a2_nxt = a2_r;
    if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE: enable_nxt = cfg.data[0];
        REG_B0:     b0_nxt = cfg.data;
        REG_B1:     b1_nxt = cfg.data;
        REG_B2:     b2_nxt = cfg.data;
        REG_A1:     a1_nxt = cfg.data;
        REG_A2:     a2_nxt = cfg.data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    x_nxt          = cmd.load_x ? mono_sum[SAMPLE_W:1] : x_r;
    acc_nxt        = cmd.mac_en ? (cmd.sub ? base - prod_ext : base + prod_ext) : acc_r;
    y_nxt          = cmd.y_load ? y_sat : (cmd.y_pass ? x_r : y_r);
    d1_nxt         = cmd.d1_load ? d_sat : d1_r;
    d2_nxt         = cmd.d2_load ? d_sat : d2_r;
    out_sample_nxt = cmd.out_load ? y_r : out_sample_r;
    out_valid_nxt  = cmd.out_load | (out_valid_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      b0_r        <= B0_RESET;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      enable_r    <= enable_nxt;
      b0_r        <= b0_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
  end

endmodule

// ===== rtl/core/peq_ctrl.sv =====
// ----------------------------------------------------------------------------
// peq_ctrl
// Sequencer stepping the shared multiplier through the biquad update.
// ----------------------------------------------------------------------------
module peq_ctrl import peq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  peq_status_t status,
  output peq_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PASS = 4'd1;
  localparam logic [3:0] ST_MB0  = 4'd2;
  localparam logic [3:0] ST_SATY = 4'd3;
  localparam logic [3:0] ST_MB1  = 4'd4;
  localparam logic [3:0] ST_MA1  = 4'd5;
  localparam logic [3:0] ST_MB2  = 4'd6;
  localparam logic [3:0] ST_MA2  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt  = status.enable ? ST_MB0 : ST_PASS;
        end
      end
      ST_PASS: begin
        cmd.y_pass = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_MB0: begin
        cmd.mac_en   = 1'b1;
        cmd.coef_sel = SEL_B0;
        cmd.base_sel = BASE_D1;
        state_nxt    = ST_SATY;
      end
      ST_SATY: begin
        cmd.y_load = 1'b1;
        state_nxt  = ST_MB1;
      end
      ST_MB1: begin
        cmd.mac_en   = 1'b1;
        cmd.coef_sel = SEL_B1;
        cmd.base_sel = BASE_D2;
        state_nxt    = ST_MA1;
      end
      ST_MA1: begin
        cmd.mac_en   = 1'b1;
        cmd.coef_sel = SEL_A1;
        cmd.base_sel = BASE_ACC;
        cmd.sub      = 1'b1;
        cmd.use_y    = 1'b1;
        state_nxt    = ST_MB2;
      end
      ST_MB2: begin
        cmd.d1_load  = 1'b1;
        cmd.mac_en   = 1'b1;
        cmd.coef_sel = SEL_B2;
        cmd.base_sel = BASE_ZERO;
        state_nxt    = ST_MA2;
      end
      ST_MA2: begin
        cmd.mac_en   = 1'b1;
        cmd.coef_sel = SEL_A2;
        cmd.base_sel = BASE_ACC;
        cmd.sub      = 1'b1;
        cmd.use_y    = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        cmd.d2_load = status.enable;
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // delay two is written once only
    if (state_r == ST_DONE && status.out_busy) cmd.d2_load = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/peaking_eq_biquad_unit.sv =====
// ----------------------------------------------------------------------------
// peaking_eq_biquad_unit
// Stereo-to-mono mix followed by a fixed-point transposed DF-II biquad.
// ----------------------------------------------------------------------------
// in_ch carries a left/right sample pair, out_ch one saturated mono sample
// per item, cfg_ch register writes (0 enable, 1..5 b0 b1 b2 a1 a2, Q3.14).
// cfg_ch is always ready; write it only while the unit is idle.
// One item at a time: the sequencer drives a single 18x16 multiplier through
// the five products: a filtered item steps through MB0, SATY, MB1, MA1, MB2,
// MA2 and DONE before its result is loaded, and the next item is taken only
// in idle. With the filter disabled the mono sample goes through PASS and
// DONE to the output register; the delay state is left untouched.
// The result sits in an output register. While out_ch stalls, one more item
// is taken and worked through, then held in the last step until the
// register drains; no item is dropped.
// Reset clears the delays and output valid, disables the filter and loads
// unity b0 with the other coefficients at zero.
// ----------------------------------------------------------------------------
module peaking_eq_biquad_unit import peq_pkg::*; #(
  parameter int FRAC_BITS = COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  peq_in_if.sink     in_ch,
  peq_out_if.source  out_ch,
  peq_cfg_if.sink    cfg_ch
);

  peq_cmd_t    cmd;
  peq_status_t status;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  peq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  peq_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .cfg          (cfg_ch),
    .out_ch       (out_ch)
  );

endmodule
